// ===== hdl/lsd_pkg.sv =====
// Shared constants, command codes and status struct of the radix sorter.
`default_nettype none
package lsd_pkg;
	localparam int KEY_W     = 32;
	localparam int MAX_KEYS  = 64;
	localparam int KIDX_W    = $clog2(MAX_KEYS);
	localparam int FILL_W    = KIDX_W + 1;
	localparam int MAX_RADIX = 256;
	localparam int RADIX_W   = 9;
	localparam int DIG_W     = $clog2(MAX_RADIX);
	localparam int CNT_W     = FILL_W;
	localparam int IDX_W     = DIG_W + 1;
	localparam int ENT_W     = 2 * KEY_W;
	localparam int DIVC_W    = $clog2(KEY_W);
	localparam logic [RADIX_W-1:0] RADIX_RST = RADIX_W'(10);

	typedef enum logic [4:0] {
		OP_LOAD, OP_CLR, OP_DIV_RD, OP_DIV_GO, OP_DIV_WAIT, OP_CNT_WR,
		OP_PFX_RD, OP_PFX_WR, OP_SC_RD, OP_SC_CNT, OP_SC_WR,
		OP_CP_RD, OP_CP_WR, OP_OUT_RD, OP_OUT_LD, OP_OUT_HOLD
	} op_t;

	typedef struct packed {
		logic last_xfer;
		logic div_done;
		logic key_end;
		logic key_first;
		logic cnt_end;
		logic any_nz;
		logic out_xfer;
		logic out_last;
	} status_t;
endpackage
`default_nettype wire

// ===== hdl/lsd_div.sv =====
// Restoring divider, one quotient bit per cycle: quotient and remainder of a key.
`default_nettype none
module lsd_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [lsd_pkg::KEY_W-1:0]    dividend,
	input  wire logic [lsd_pkg::RADIX_W-1:0]  divisor,
	output logic      [lsd_pkg::KEY_W-1:0]    quot,
	output logic      [lsd_pkg::DIG_W-1:0]    rem,
	output logic                              done
);
	logic [lsd_pkg::KEY_W-1:0]   q_q;
	logic [lsd_pkg::RADIX_W-1:0] r_q;
	logic [lsd_pkg::DIVC_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [lsd_pkg::RADIX_W:0]   trial;
	logic                        ge;

	assign trial = {r_q, q_q[lsd_pkg::KEY_W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {lsd_pkg::DIVC_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[lsd_pkg::KEY_W-2:0], ge};
			r_q <= ge ? lsd_pkg::RADIX_W'(trial - {1'b0, divisor})
			          : trial[lsd_pkg::RADIX_W-1:0];
		end
	end

	assign quot = q_q;
	assign rem  = r_q[lsd_pkg::DIG_W-1:0];
	assign done = done_q;
endmodule
`default_nettype wire

// ===== hdl/lsd_dp.sv =====
// Datapath: key, digit, count and scatter memories, divider, output register.
`default_nettype none
module lsd_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lsd_pkg::op_t                  op,
	output lsd_pkg::status_t                   st,
	input  wire logic                          radix_we,
	input  wire logic [lsd_pkg::RADIX_W-1:0]   radix_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lsd_pkg::KEY_W-1:0]     in_key,
	input  wire logic                          in_last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [lsd_pkg::KEY_W-1:0]     out_key,
	output logic                               out_last,
	output logic                               out_trunc
);
	logic [lsd_pkg::RADIX_W-1:0] radix_q;
	logic [lsd_pkg::RADIX_W-1:0] base;
	logic [lsd_pkg::IDX_W-1:0]   idx_q;
	logic [lsd_pkg::FILL_W-1:0]  fill_q;
	logic                        ovf_q;
	logic                        any_nz_q;
	logic [lsd_pkg::CNT_W-1:0]   sum_q;
	logic [lsd_pkg::DIG_W-1:0]   dig_q;
	logic                        out_valid_q;
	logic [lsd_pkg::KEY_W-1:0]   out_key_q;
	logic                        out_last_q;
	logic                        out_trunc_q;

	logic [lsd_pkg::ENT_W-1:0]   key_mem [lsd_pkg::MAX_KEYS];
	logic [lsd_pkg::ENT_W-1:0]   scat_mem [lsd_pkg::MAX_KEYS];
	logic [lsd_pkg::DIG_W-1:0]   dig_mem [lsd_pkg::MAX_KEYS];
	logic [lsd_pkg::CNT_W-1:0]   cnt_mem [lsd_pkg::MAX_RADIX];
	logic [lsd_pkg::ENT_W-1:0]   key_rd_q;
	logic [lsd_pkg::ENT_W-1:0]   scat_rd_q;
	logic [lsd_pkg::DIG_W-1:0]   dig_rd_q;
	logic [lsd_pkg::CNT_W-1:0]   cnt_rd_q;

	logic                        key_we;
	logic [lsd_pkg::KIDX_W-1:0]  key_wa;
	logic [lsd_pkg::ENT_W-1:0]   key_wd;
	logic                        cnt_we;
	logic [lsd_pkg::DIG_W-1:0]   cnt_wa;
	logic [lsd_pkg::CNT_W-1:0]   cnt_wd;
	logic [lsd_pkg::DIG_W-1:0]   cnt_ra;
	logic [lsd_pkg::CNT_W-1:0]   cnt_dec;
	logic [lsd_pkg::CNT_W-1:0]   pfx;

	logic                        in_xfer;
	logic                        out_xfer;
	logic                        key_end;
	logic                        cnt_end;
	logic                        div_done;
	logic [lsd_pkg::KEY_W-1:0]   div_q;
	logic [lsd_pkg::DIG_W-1:0]   div_r;
	logic [lsd_pkg::KIDX_W-1:0]  kidx;

	always_comb begin
		priority if (radix_q < lsd_pkg::RADIX_W'(2))
			base = lsd_pkg::RADIX_W'(2);
		else if (radix_q > lsd_pkg::RADIX_W'(lsd_pkg::MAX_RADIX))
			base = lsd_pkg::RADIX_W'(lsd_pkg::MAX_RADIX);
		else
			base = radix_q;
	end

	assign kidx     = idx_q[lsd_pkg::KIDX_W-1:0];
	assign in_ready = (op == lsd_pkg::OP_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign key_end  = idx_q == lsd_pkg::IDX_W'(fill_q - 1'b1);
	assign cnt_end  = idx_q == lsd_pkg::IDX_W'(base - 1'b1);
	assign cnt_dec  = cnt_rd_q - 1'b1;
	assign pfx      = sum_q + cnt_rd_q;

	lsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op == lsd_pkg::OP_DIV_GO),
		.dividend (key_rd_q[lsd_pkg::ENT_W-1:lsd_pkg::KEY_W]),
		.divisor  (base),
		.quot     (div_q),
		.rem      (div_r),
		.done     (div_done)
	);

	always_comb begin
		key_we = 1'b0;
		key_wa = kidx;
		key_wd = {div_q, key_rd_q[lsd_pkg::KEY_W-1:0]};
		cnt_we = 1'b0;
		cnt_wa = idx_q[lsd_pkg::DIG_W-1:0];
		cnt_wd = '0;
		cnt_ra = idx_q[lsd_pkg::DIG_W-1:0];
		unique case (op)
			lsd_pkg::OP_LOAD: begin
				key_we = in_xfer && (fill_q < lsd_pkg::FILL_W'(lsd_pkg::MAX_KEYS));
				key_wa = fill_q[lsd_pkg::KIDX_W-1:0];
				key_wd = {in_key, in_key};
			end
			lsd_pkg::OP_CLR: cnt_we = 1'b1;
			lsd_pkg::OP_DIV_WAIT: begin
				key_we = div_done;
				cnt_ra = div_r;
			end
			lsd_pkg::OP_CNT_WR: begin
				cnt_we = 1'b1;
				cnt_wa = dig_q;
				cnt_wd = cnt_rd_q + 1'b1;
			end
			lsd_pkg::OP_PFX_WR: begin
				cnt_we = 1'b1;
				cnt_wd = pfx;
			end
			lsd_pkg::OP_SC_CNT: cnt_ra = dig_rd_q;
			lsd_pkg::OP_SC_WR: begin
				cnt_we = 1'b1;
				cnt_wa = dig_rd_q;
				cnt_wd = cnt_dec;
			end
			lsd_pkg::OP_CP_WR: begin
				key_we = 1'b1;
				key_wd = scat_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_wa] <= key_wd;
		key_rd_q <= key_mem[kidx];
		if (op == lsd_pkg::OP_DIV_WAIT && div_done)
			dig_mem[kidx] <= div_r;
		dig_rd_q <= dig_mem[kidx];
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_ra];
		if (op == lsd_pkg::OP_SC_WR)
			scat_mem[cnt_dec[lsd_pkg::KIDX_W-1:0]] <= key_rd_q;
		scat_rd_q <= scat_mem[kidx];
		if (op == lsd_pkg::OP_DIV_WAIT && div_done)
			dig_q <= div_r;
		if (op == lsd_pkg::OP_OUT_LD) begin
			out_key_q   <= key_rd_q[lsd_pkg::KEY_W-1:0];
			out_last_q  <= key_end;
			out_trunc_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= lsd_pkg::RADIX_RST;
			idx_q       <= '0;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			any_nz_q    <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (radix_we)
				radix_q <= radix_wdata;
			unique case (op)
				lsd_pkg::OP_LOAD: begin
					idx_q <= '0;
					if (in_xfer) begin
						if (fill_q < lsd_pkg::FILL_W'(lsd_pkg::MAX_KEYS))
							fill_q <= fill_q + 1'b1;
						else
							ovf_q <= 1'b1;
					end
				end
				lsd_pkg::OP_CLR: begin
					idx_q    <= cnt_end ? '0 : idx_q + 1'b1;
					any_nz_q <= 1'b0;
					sum_q    <= '0;
				end
				lsd_pkg::OP_DIV_WAIT: begin
					if (div_done && div_r != '0)
						any_nz_q <= 1'b1;
				end
				lsd_pkg::OP_CNT_WR: idx_q <= key_end ? '0 : idx_q + 1'b1;
				lsd_pkg::OP_PFX_WR: begin
					sum_q <= pfx;
					idx_q <= cnt_end ? lsd_pkg::IDX_W'(fill_q - 1'b1) : idx_q + 1'b1;
				end
				lsd_pkg::OP_SC_WR: idx_q <= (idx_q == '0) ? '0 : idx_q - 1'b1;
				lsd_pkg::OP_CP_WR: idx_q <= key_end ? '0 : idx_q + 1'b1;
				lsd_pkg::OP_OUT_LD: out_valid_q <= 1'b1;
				lsd_pkg::OP_OUT_HOLD: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							idx_q  <= '0;
							fill_q <= '0;
							ovf_q  <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign st.last_xfer = in_xfer && in_last;
	assign st.div_done  = div_done;
	assign st.key_end   = key_end;
	assign st.key_first = (idx_q == '0);
	assign st.cnt_end   = cnt_end;
	assign st.any_nz    = any_nz_q;
	assign st.out_xfer  = out_xfer;
	assign st.out_last  = out_last_q;

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_last  = out_last_q;
	assign out_trunc = out_trunc_q;

`ifndef SYNTHESIS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lsd_pkg::FILL_W'(lsd_pkg::MAX_KEYS))
		else $error("fill count beyond capacity");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> fill_q == lsd_pkg::FILL_W'(lsd_pkg::MAX_KEYS))
		else $error("overflow flagged with room left");
	a_no_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready)
		else $error("loading while a result is pending");
`endif
endmodule
`default_nettype wire

// ===== hdl/lsd_ctrl.sv =====
// Controller: sequences load, count, prefix, scatter, copy and output phases.
`default_nettype none
module lsd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lsd_pkg::status_t st,
	output lsd_pkg::op_t          op
);
	typedef enum logic [4:0] {
		S_LOAD, S_CLR, S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_CNT_WR,
		S_PFX_RD, S_PFX_WR, S_SC_RD, S_SC_CNT, S_SC_WR,
		S_CP_RD, S_CP_WR, S_OUT_RD, S_OUT_LD, S_OUT_HOLD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD:     if (st.last_xfer) state_q <= S_CLR;
				S_CLR:      if (st.cnt_end) state_q <= S_DIV_RD;
				S_DIV_RD:   state_q <= S_DIV_GO;
				S_DIV_GO:   state_q <= S_DIV_WAIT;
				S_DIV_WAIT: if (st.div_done) state_q <= S_CNT_WR;
				S_CNT_WR: begin
					if (!st.key_end)
						state_q <= S_DIV_RD;
					else
						state_q <= st.any_nz ? S_PFX_RD : S_OUT_RD;
				end
				S_PFX_RD:   state_q <= S_PFX_WR;
				S_PFX_WR:   state_q <= st.cnt_end ? S_SC_RD : S_PFX_RD;
				S_SC_RD:    state_q <= S_SC_CNT;
				S_SC_CNT:   state_q <= S_SC_WR;
				S_SC_WR:    state_q <= st.key_first ? S_CP_RD : S_SC_RD;
				S_CP_RD:    state_q <= S_CP_WR;
				S_CP_WR:    state_q <= st.key_end ? S_CLR : S_CP_RD;
				S_OUT_RD:   state_q <= S_OUT_LD;
				S_OUT_LD:   state_q <= S_OUT_HOLD;
				S_OUT_HOLD: begin
					if (st.out_xfer)
						state_q <= st.out_last ? S_LOAD : S_OUT_RD;
				end
				default:    state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			S_LOAD:     op = lsd_pkg::OP_LOAD;
			S_CLR:      op = lsd_pkg::OP_CLR;
			S_DIV_RD:   op = lsd_pkg::OP_DIV_RD;
			S_DIV_GO:   op = lsd_pkg::OP_DIV_GO;
			S_DIV_WAIT: op = lsd_pkg::OP_DIV_WAIT;
			S_CNT_WR:   op = lsd_pkg::OP_CNT_WR;
			S_PFX_RD:   op = lsd_pkg::OP_PFX_RD;
			S_PFX_WR:   op = lsd_pkg::OP_PFX_WR;
			S_SC_RD:    op = lsd_pkg::OP_SC_RD;
			S_SC_CNT:   op = lsd_pkg::OP_SC_CNT;
			S_SC_WR:    op = lsd_pkg::OP_SC_WR;
			S_CP_RD:    op = lsd_pkg::OP_CP_RD;
			S_CP_WR:    op = lsd_pkg::OP_CP_WR;
			S_OUT_RD:   op = lsd_pkg::OP_OUT_RD;
			S_OUT_LD:   op = lsd_pkg::OP_OUT_LD;
			S_OUT_HOLD: op = lsd_pkg::OP_OUT_HOLD;
			default:    op = lsd_pkg::OP_LOAD;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/lsd_radix_sorter.sv =====
// Top level of the LSD radix sorter: controller plus datapath.
// Usage:
//  s_axis carries keys (tdata) one per transfer, tlast marks the final key of a set.
//  Keys load at one per cycle; beyond 64 keys they are dropped and flagged.
//  After the last key the block sorts with counting passes in base radix
//  (clamped to 2..256); the user writes it through radix_we/radix_wdata only while
//  idle, which the block itself does not enforce. Each pass clears the counts,
//  divides each key for its digit (one-bit-per-cycle divider) and counts it,
//  forms prefix sums, scatters keys last to first and copies them back. Passes
//  repeat until all digits are zero; that final pass stops after the count walk.
//  m_axis then gives the sorted keys, each read, registered and held until
//  taken, tlast on the final key, tuser set on every key if keys were dropped.
//  s_axis_tready is low from the last key until the final result transfer.
//  A stalled receiver holds the output register and the block waits.
//  Reset clears the set in progress and sets radix to 10.
`default_nettype none
module lsd_radix_sorter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          radix_we,
	input  wire logic [lsd_pkg::RADIX_W-1:0]   radix_wdata,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [lsd_pkg::KEY_W-1:0]     s_axis_tdata,  // key
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [lsd_pkg::KEY_W-1:0]     m_axis_tdata,  // sorted_key
	output logic                               m_axis_tlast,
	output logic                               m_axis_tuser   // truncated
);
	lsd_pkg::op_t     op;
	lsd_pkg::status_t st;

	lsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.op     (op)
	);

	lsd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.st          (st),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_key      (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_key     (m_axis_tdata),
		.out_last    (m_axis_tlast),
		.out_trunc   (m_axis_tuser)
	);
endmodule
`default_nettype wire
